@@ rtl/nine_point_aim_calibration_mapper_unit_defines.svh @@
// Assertion macros shared by the nine-point aim calibration mapper.
`ifndef NINE_POINT_AIM_CALIBRATION_MAPPER_UNIT_DEFINES_SVH
`define NINE_POINT_AIM_CALIBRATION_MAPPER_UNIT_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define NPACM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define NPACM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/npacm_pkg.sv @@
// Types, constants and helper functions of the aim calibration mapper.
`timescale 1ns / 1ps
package npacm_pkg;

    localparam int ANGLE_W     = 16;
    localparam int SIZE_W      = 13;
    localparam int EDGE_MARGIN = 30;
    localparam int FRAC_SH     = 22;
    localparam int DIFF_W      = ANGLE_W + 1;
    localparam int GAIN_W      = 32;
    localparam int PROD_W      = DIFF_W + GAIN_W;
    localparam int PIX_W       = PROD_W + 1;
    localparam int ACC_W       = ANGLE_W + 2;
    localparam int HALF_W      = SIZE_W - 1;
    localparam int NUM_W       = HALF_W + 2;
    localparam int FULL_W      = SIZE_W + FRAC_SH;
    localparam int POS_W       = 16;
    localparam int DVS_W       = FULL_W;
    localparam int DVD_W       = FULL_W + POS_W;
    localparam int CNT_W       = $clog2(DVD_W);
    localparam int NSAMP       = 9;
    localparam int SADDR_W     = 4;
    localparam int NAVG        = 6;
    localparam int NGAIN       = 4;
    localparam int K_W         = 3;

    // Division by three as a reciprocal multiply: floor(m * DIV3_MUL / 2^DIV3_SH)
    // equals floor(m / 3) for every m below 2^17, which covers a sum of three angles.
    localparam int               DIV3_SH  = 18;
    localparam logic [ACC_W-1:0] DIV3_MUL = 18'd87382;

    localparam logic [GAIN_W-1:0] GAIN_MAX = 32'h7FFF_FFFF;
    localparam logic [GAIN_W-1:0] GAIN_MIN = 32'h8000_0000;

    localparam logic [SIZE_W-1:0] WIDTH_RST  = 13'd1920;
    localparam logic [SIZE_W-1:0] HEIGHT_RST = 13'd1080;

    // Configuration register indexes.
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // Request codes.
    typedef logic [1:0] t_req;
    localparam t_req REQ_START = 2'd0;
    localparam t_req REQ_CAL   = 2'd1;
    localparam t_req REQ_AIM   = 2'd2;

    // Averages, in the order they are computed.
    localparam logic [K_W-1:0] AVG_LEFT  = 3'd0;
    localparam logic [K_W-1:0] AVG_RIGHT = 3'd1;
    localparam logic [K_W-1:0] AVG_UP    = 3'd2;
    localparam logic [K_W-1:0] AVG_DOWN  = 3'd3;
    localparam logic [K_W-1:0] AVG_CX    = 3'd4;
    localparam logic [K_W-1:0] AVG_CY    = 3'd5;

    // Side gains, in storage order.
    localparam logic [K_W-1:0] GN_LEFT  = 3'd0;
    localparam logic [K_W-1:0] GN_RIGHT = 3'd1;
    localparam logic [K_W-1:0] GN_DOWN  = 3'd2;
    localparam logic [K_W-1:0] GN_UP    = 3'd3;

    typedef enum logic [1:0] {
        ST_STORED,
        ST_CAL_DONE,
        ST_POSITION,
        ST_IGNORED
    } t_status;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_CAL,
        PH_READY
    } t_phase;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AVG_RD,
        S_AVG_DIV,
        S_AVG_WR,
        S_GAIN_DIV,
        S_GAIN_WAIT,
        S_GAIN_WR,
        S_MUL,
        S_MAP_DIV,
        S_MAP_WAIT,
        S_MAP_WR,
        S_RESULT
    } t_ctrl_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_AVG_RD,
        OP_AVG_DIV,
        OP_AVG_WR,
        OP_GAIN_DIV,
        OP_GAIN_WR,
        OP_MUL,
        OP_MAP_DIV,
        OP_MAP_WR
    } t_dp_op;

    typedef struct packed {
        logic [1:0]               req_type;
        logic signed [ANGLE_W-1:0] yaw_angle;
        logic signed [ANGLE_W-1:0] pitch_angle;
        logic                     trigger;
    } t_in_req;

    typedef struct packed {
        t_status          status;
        logic [POS_W-1:0] x_position;
        logic [POS_W-1:0] y_position;
        logic             shot;
    } t_out_res;

    typedef struct packed {
        t_dp_op             op;
        logic [K_W-1:0]     k;
        logic [1:0]         j;
        logic               axis;
        logic               mem_we;
        logic [SADDR_W-1:0] mem_wa;
        logic               cap;
        logic               out_load;
        t_status            status;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
    } t_dp_sts;

    // Sample slot of the j-th term of average k. Slots follow the order in which
    // the nine calibration points are taken.
    function automatic logic [SADDR_W-1:0] avg_addr(input logic [K_W-1:0] k,
                                                    input logic [1:0] j);
        logic [SADDR_W-1:0] a0;
        logic [SADDR_W-1:0] a1;
        logic [SADDR_W-1:0] a2;
        a0 = 4'd0;
        a1 = 4'd1;
        a2 = 4'd2;
        unique case (k)
            AVG_LEFT:  begin a0 = 4'd0; a1 = 4'd1; a2 = 4'd2; end
            AVG_RIGHT: begin a0 = 4'd6; a1 = 4'd7; a2 = 4'd8; end
            AVG_UP:    begin a0 = 4'd0; a1 = 4'd5; a2 = 4'd6; end
            AVG_DOWN:  begin a0 = 4'd2; a1 = 4'd3; a2 = 4'd8; end
            AVG_CX:    begin a0 = 4'd3; a1 = 4'd4; a2 = 4'd5; end
            AVG_CY:    begin a0 = 4'd1; a1 = 4'd4; a2 = 4'd7; end
            default:   begin a0 = 4'd0; a1 = 4'd1; a2 = 4'd2; end
        endcase
        return (j == 2'd0) ? a0 : ((j == 2'd1) ? a1 : a2);
    endfunction

    // Pitch averages read the pitch store, the rest the yaw store.
    function automatic logic avg_is_pitch(input logic [K_W-1:0] k);
        return (k == AVG_UP) || (k == AVG_DOWN) || (k == AVG_CY);
    endfunction

endpackage

@@ rtl/npacm_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module npacm_div
    import npacm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dvd,
    input  logic [DVS_W-1:0] i_dvs,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quo
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVD_W-1:0] r_q;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   sub;
    logic             ge;

    assign trial = {r_rem, r_q[DVD_W-1]};
    assign sub   = trial - {1'b0, r_dvs};
    assign ge    = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dvd;
            r_dvs <= i_dvs;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? sub[DVS_W-1:0] : trial[DVS_W-1:0];
            r_q   <= {r_q[DVD_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

@@ rtl/npacm_dp.sv @@
// Datapath: sample store, averages, gains, axis mapping and result register.
`timescale 1ns / 1ps
module npacm_dp
    import npacm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_in_req           i_in,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [SIZE_W-1:0] i_cfg_data,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    output t_out_res          o_out
);

    logic [SIZE_W-1:0] r_width;
    logic [SIZE_W-1:0] r_height;

    logic signed [ANGLE_W-1:0] r_mem_yaw   [NSAMP];
    logic signed [ANGLE_W-1:0] r_mem_pitch [NSAMP];
    logic signed [ANGLE_W-1:0] r_rd_yaw;
    logic signed [ANGLE_W-1:0] r_rd_pitch;
    logic signed [ACC_W-1:0]   r_acc;
    logic [ACC_W-1:0]          r_avg_q;

    logic signed [ANGLE_W-1:0] r_left, r_right, r_up, r_down;
    logic signed [ANGLE_W-1:0] r_cx, r_cy;
    logic signed [GAIN_W-1:0]  r_gl, r_gr, r_gd, r_gu;

    logic signed [ANGLE_W-1:0] r_yaw, r_pitch;
    logic                      r_trig;
    logic signed [PROD_W-1:0]  r_prod;
    logic [POS_W-1:0]          r_x, r_y;

    logic r_neg, r_num_neg, r_num_zero, r_span_zero, r_size_zero;
    t_out_res r_out;

    logic [SADDR_W-1:0]       rd_addr;
    logic signed [ANGLE_W-1:0] rd_sel;
    logic [ACC_W-1:0]          acc_mag;
    logic [2*ACC_W-1:0]        avg_prod;

    logic [SIZE_W-1:0]        g_size;
    logic signed [NUM_W-1:0]  g_num;
    logic [NUM_W-1:0]         g_num_mag;
    logic signed [DIFF_W-1:0] g_span;
    logic [DIFF_W-1:0]        g_span_mag;

    logic signed [DIFF_W-1:0] m_diff;
    logic signed [GAIN_W-1:0] m_gain;
    logic signed [PROD_W-1:0] m_prod;
    logic [SIZE_W-1:0]        m_size;
    logic [FULL_W-1:0]        m_full;
    logic signed [PIX_W-1:0]  m_pix;
    logic [FULL_W-1:0]        m_pixc;

    logic             div_start;
    logic [DVD_W-1:0] div_dvd;
    logic [DVS_W-1:0] div_dvs;
    logic             div_done;
    logic [DVD_W-1:0] div_quo;
    logic             n_neg;

    logic [ACC_W-1:0]  avg_q;
    logic [ACC_W-1:0]  avg_val;
    logic [GAIN_W-1:0] gain_val;

    npacm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_dvd   (div_dvd),
        .i_dvs   (div_dvs),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign o_sts.div_done = div_done;
    assign o_out          = r_out;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_WIDTH) begin
                r_width <= i_cfg_data;
            end else begin
                r_height <= i_cfg_data;
            end
        end
    end

    // Sample store with a registered read port.
    assign rd_addr = avg_addr(i_cmd.k, i_cmd.j);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            r_mem_yaw[i_cmd.mem_wa]   <= i_in.yaw_angle;
            r_mem_pitch[i_cmd.mem_wa] <= i_in.pitch_angle;
        end
        if (i_cmd.op == OP_AVG_RD && i_cmd.j != 2'd3) begin
            r_rd_yaw   <= r_mem_yaw[rd_addr];
            r_rd_pitch <= r_mem_pitch[rd_addr];
        end
    end

    assign rd_sel  = avg_is_pitch(i_cmd.k) ? r_rd_pitch : r_rd_yaw;
    assign acc_mag = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);

    // The magnitude of the sum is divided by three with a reciprocal multiply.
    assign avg_prod = (2*ACC_W)'(acc_mag) * (2*ACC_W)'(DIV3_MUL);

    // Gain operands: numerator is half the screen less the margin.
    assign g_size    = i_cmd.k[1] ? r_height : r_width;
    assign g_num     = $signed({2'b00, g_size[SIZE_W-1:1]}) - NUM_W'(EDGE_MARGIN);
    assign g_num_mag = g_num[NUM_W-1] ? NUM_W'(-g_num) : NUM_W'(g_num);

    always_comb begin
        case (i_cmd.k)
            GN_LEFT:  g_span = DIFF_W'(r_cx) - DIFF_W'(r_left);
            GN_RIGHT: g_span = DIFF_W'(r_right) - DIFF_W'(r_cx);
            GN_DOWN:  g_span = DIFF_W'(r_cy) - DIFF_W'(r_down);
            default:  g_span = DIFF_W'(r_up) - DIFF_W'(r_cy);
        endcase
    end
    assign g_span_mag = g_span[DIFF_W-1] ? DIFF_W'(-g_span) : DIFF_W'(g_span);

    // Axis mapping operands.
    always_comb begin
        if (!i_cmd.axis) begin
            m_diff = DIFF_W'(r_yaw) - DIFF_W'(r_cx);
            m_gain = (r_yaw < r_cx) ? r_gl : r_gr;
        end else begin
            m_diff = DIFF_W'(r_cy) - DIFF_W'(r_pitch);
            m_gain = (r_pitch < r_cy) ? r_gd : r_gu;
        end
    end
    assign m_prod = m_diff * m_gain;

    assign m_size = i_cmd.axis ? r_height : r_width;
    assign m_full = {m_size, {FRAC_SH{1'b0}}};
    assign m_pix  = $signed({{(PIX_W - HALF_W - FRAC_SH){1'b0}}, m_size[SIZE_W-1:1],
                             {FRAC_SH{1'b0}}}) + PIX_W'(r_prod);

    always_comb begin
        if (m_pix[PIX_W-1]) begin
            m_pixc = '0;
        end else if (m_pix[PIX_W-2:0] > (PIX_W-1)'(m_full)) begin
            m_pixc = m_full;
        end else begin
            m_pixc = m_pix[FULL_W-1:0];
        end
    end

    // Divider operand selection.
    always_comb begin
        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = '0;
        n_neg     = r_neg;
        case (i_cmd.op)
            OP_AVG_DIV: begin
                n_neg = r_acc[ACC_W-1];
            end
            OP_GAIN_DIV: begin
                div_start = 1'b1;
                div_dvd   = DVD_W'({g_num_mag, {FRAC_SH{1'b0}}});
                div_dvs   = DVS_W'(g_span_mag);
                n_neg     = g_num[NUM_W-1] ^ g_span[DIFF_W-1];
            end
            OP_MAP_DIV: begin
                div_start = 1'b1;
                div_dvd   = {m_pixc, {POS_W{1'b0}}} - DVD_W'(m_pixc);
                div_dvs   = m_full;
            end
            default: ;
        endcase
    end

    assign avg_q   = r_avg_q;
    assign avg_val = r_neg ? ACC_W'(-avg_q) : avg_q;

    always_comb begin
        if (r_span_zero) begin
            gain_val = r_num_zero ? '0 : (r_num_neg ? GAIN_MIN : GAIN_MAX);
        end else if (!r_neg) begin
            gain_val = (div_quo > DVD_W'(GAIN_MAX)) ? GAIN_MAX : div_quo[GAIN_W-1:0];
        end else begin
            gain_val = (div_quo > DVD_W'(GAIN_MIN)) ? GAIN_MIN
                                                    : GAIN_W'(-div_quo[GAIN_W-1:0]);
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_neg <= n_neg;
        if (i_cmd.op == OP_AVG_RD) begin
            r_acc <= (i_cmd.j == 2'd0) ? '0 : r_acc + ACC_W'(rd_sel);
        end
        if (i_cmd.op == OP_AVG_DIV) begin
            r_avg_q <= avg_prod[DIV3_SH +: ACC_W];
        end
        if (i_cmd.op == OP_GAIN_DIV) begin
            r_num_neg   <= g_num[NUM_W-1];
            r_num_zero  <= (g_num == '0);
            r_span_zero <= (g_span == '0);
        end
        if (i_cmd.op == OP_AVG_WR) begin
            case (i_cmd.k)
                AVG_LEFT:  r_left  <= avg_val[ANGLE_W-1:0];
                AVG_RIGHT: r_right <= avg_val[ANGLE_W-1:0];
                AVG_UP:    r_up    <= avg_val[ANGLE_W-1:0];
                AVG_DOWN:  r_down  <= avg_val[ANGLE_W-1:0];
                default:   ;
            endcase
        end
        if (i_cmd.cap) begin
            r_yaw   <= i_in.yaw_angle;
            r_pitch <= i_in.pitch_angle;
            r_trig  <= i_in.trigger;
        end
        if (i_cmd.op == OP_MUL) begin
            r_prod <= m_prod;
        end
        if (i_cmd.op == OP_MAP_DIV) begin
            r_size_zero <= (m_size == '0);
        end
        if (i_cmd.op == OP_MAP_WR) begin
            if (!i_cmd.axis) begin
                r_x <= r_size_zero ? '0 : div_quo[POS_W-1:0];
            end else begin
                r_y <= r_size_zero ? '0 : div_quo[POS_W-1:0];
            end
        end
        if (i_cmd.out_load) begin
            r_out.status <= i_cmd.status;
            if (i_cmd.status == ST_POSITION) begin
                r_out.x_position <= r_x;
                r_out.y_position <= r_y;
                r_out.shot       <= r_trig;
            end else begin
                r_out.x_position <= '0;
                r_out.y_position <= '0;
                r_out.shot       <= 1'b0;
            end
        end
    end

    // Calibration results that survive until the next complete calibration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0;
            r_cy <= '0;
            r_gl <= '0;
            r_gr <= '0;
            r_gd <= '0;
            r_gu <= '0;
        end else begin
            if (i_cmd.op == OP_AVG_WR) begin
                if (i_cmd.k == AVG_CX) begin
                    r_cx <= avg_val[ANGLE_W-1:0];
                end
                if (i_cmd.k == AVG_CY) begin
                    r_cy <= avg_val[ANGLE_W-1:0];
                end
            end
            if (i_cmd.op == OP_GAIN_WR) begin
                case (i_cmd.k)
                    GN_LEFT:  r_gl <= gain_val;
                    GN_RIGHT: r_gr <= gain_val;
                    GN_DOWN:  r_gd <= gain_val;
                    default:  r_gu <= gain_val;
                endcase
            end
        end
    end

endmodule

@@ rtl/npacm_ctrl.sv @@
// Controller: request decode, calibration phase and operation sequencing.
`timescale 1ns / 1ps
module npacm_ctrl
    import npacm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_req    i_req_type,
    input  logic    i_out_stall,
    input  t_dp_sts i_sts,
    output logic    o_in_stall,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    t_ctrl_state        r_state, n_state;
    t_phase             r_phase, n_phase;
    logic [SADDR_W-1:0] r_idx, n_idx;
    logic [K_W-1:0]     r_k, n_k;
    logic [1:0]         r_j, n_j;
    logic               r_axis, n_axis;
    t_status            r_status, n_status;
    logic               r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_IDLE;
            r_idx       <= '0;
            r_k         <= '0;
            r_j         <= '0;
            r_axis      <= 1'b0;
            r_status    <= ST_IGNORED;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_idx       <= n_idx;
            r_k         <= n_k;
            r_j         <= n_j;
            r_axis      <= n_axis;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_idx    = r_idx;
        n_k      = r_k;
        n_j      = r_j;
        n_axis   = r_axis;
        n_status = r_status;

        o_cmd          = '0;
        o_cmd.op       = OP_NONE;
        o_cmd.k        = r_k;
        o_cmd.j        = r_j;
        o_cmd.axis     = r_axis;
        o_cmd.mem_wa   = r_idx;
        o_cmd.status   = r_status;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    if (i_req_type == REQ_START) begin
                        n_phase  = PH_CAL;
                        n_idx    = '0;
                        n_status = ST_STORED;
                        n_state  = S_RESULT;
                    end else if (i_req_type == REQ_CAL && r_phase == PH_CAL) begin
                        if (r_idx > SADDR_W'(NSAMP - 1)) begin
                            n_idx    = '0;
                            n_status = ST_IGNORED;
                            n_state  = S_RESULT;
                        end else begin
                            o_cmd.mem_we = 1'b1;
                            if (r_idx == SADDR_W'(NSAMP - 1)) begin
                                n_idx    = '0;
                                n_phase  = PH_READY;
                                n_status = ST_CAL_DONE;
                                n_k      = '0;
                                n_j      = '0;
                                n_state  = S_AVG_RD;
                            end else begin
                                n_idx    = r_idx + 1'b1;
                                n_status = ST_STORED;
                                n_state  = S_RESULT;
                            end
                        end
                    end else if (i_req_type == REQ_AIM && r_phase == PH_READY) begin
                        n_status = ST_POSITION;
                        n_axis   = 1'b0;
                        n_state  = S_MUL;
                    end else begin
                        n_status = ST_IGNORED;
                        n_state  = S_RESULT;
                    end
                end
            end
            S_AVG_RD: begin
                o_cmd.op = OP_AVG_RD;
                n_j      = r_j + 1'b1;
                if (r_j == 2'd3) begin
                    n_state = S_AVG_DIV;
                end
            end
            S_AVG_DIV: begin
                o_cmd.op = OP_AVG_DIV;
                n_state  = S_AVG_WR;
            end
            S_AVG_WR: begin
                o_cmd.op = OP_AVG_WR;
                n_j      = '0;
                if (r_k == K_W'(NAVG - 1)) begin
                    n_k     = '0;
                    n_state = S_GAIN_DIV;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_AVG_RD;
                end
            end
            S_GAIN_DIV: begin
                o_cmd.op = OP_GAIN_DIV;
                n_state  = S_GAIN_WAIT;
            end
            S_GAIN_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_GAIN_WR;
                end
            end
            S_GAIN_WR: begin
                o_cmd.op = OP_GAIN_WR;
                if (r_k == K_W'(NGAIN - 1)) begin
                    n_k     = '0;
                    n_state = S_RESULT;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_GAIN_DIV;
                end
            end
            S_MUL: begin
                o_cmd.op = OP_MUL;
                n_state  = S_MAP_DIV;
            end
            S_MAP_DIV: begin
                o_cmd.op = OP_MAP_DIV;
                n_state  = S_MAP_WAIT;
            end
            S_MAP_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_MAP_WR;
                end
            end
            S_MAP_WR: begin
                o_cmd.op = OP_MAP_WR;
                if (r_axis) begin
                    n_state = S_RESULT;
                end else begin
                    n_axis  = 1'b1;
                    n_state = S_MUL;
                end
            end
            S_RESULT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/nine_point_aim_calibration_mapper_unit.sv @@
// Top level of the nine-point aim calibration mapper.
`timescale 1ns / 1ps
`include "nine_point_aim_calibration_mapper_unit_defines.svh"
// Turns yaw and pitch samples from an orientation sensor into pointer positions.
// Input channel (i_in_valid / o_in_stall) carries one request: start calibration,
// calibration sample or aim sample. Output channel (o_out_valid / i_out_stall)
// returns exactly one result per request with a status and, for aim requests,
// the x and y position scaled to 0..65535 and the echoed trigger.
// Requests are taken one at a time; o_in_stall is high while a request is in work.
// Start and plain sample requests go straight from acceptance to the result step.
// An aim request runs, per axis, a multiply step and one pass of the
// shared restoring divider that scales the pixel to full range.
// The ninth calibration sample runs six averages (four sample store steps and a
// divide by three as a reciprocal multiply each) and four side gains
// through the shared divider, which sets the rate of the block.
// Results sit in an output register, so a new request is taken while the previous
// result still waits; a finished result waits in its last step until the register
// frees up. A stalled result holds its value.
// Synchronous reset restores 1920 x 1080, the uncalibrated phase and clears the
// centres and gains. The sample store is not cleared; it is always refilled before use.
// Screen size registers are written through i_cfg_we / i_cfg_idx / i_cfg_data;
// the user must write them only while no request is in work; it is not enforced.
module nine_point_aim_calibration_mapper_unit
    import npacm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_req           i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_res          o_out,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [SIZE_W-1:0] i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // The controller owns phase, sample index and sequencing of the datapath.
    npacm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_req_type  (i_in.req_type),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // The datapath holds the samples, calibration results and the divider.
    npacm_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out      (o_out)
    );

    // Every accepted request closes the input side in the following cycle.
    `NPACM_ASSERT_NEXT(a_accept_closes, i_in_valid && !o_in_stall, o_in_stall, "input not closed after accept")
    // Only a position result carries coordinates or a shot.
    `NPACM_ASSERT_NOW(a_zero_fields, o_out_valid && o_out.status != ST_POSITION, o_out.x_position == 16'd0 && o_out.y_position == 16'd0 && !o_out.shot, "non-position result with data")
    // A fresh result is loaded only as the controller returns to idle.
    `NPACM_ASSERT_NEXT(a_load_to_idle, o_out_valid && !i_out_stall, !o_out_valid || !o_in_stall, "result loaded outside idle return")

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the nine-point aim calibration mapper.
`timescale 1ns / 1ps
module testbench;
    import npacm_pkg::*;

    // Request code 3 is not used by the block; it must be ignored.
    localparam t_req REQ_BAD = 2'd3;
    localparam int   N_ITEMS = 1700;
    localparam int   WD_LIMIT = 20000;
    localparam longint ONE_Q22 = 64'sd1 << FRAC_SH;
    localparam longint unsigned PROD_CAP = 64'd1 << 62;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    t_in_req           i_in;
    logic              o_out_valid;
    logic              i_out_stall;
    t_out_res          o_out;
    logic              i_cfg_we;
    logic              i_cfg_idx;
    logic [SIZE_W-1:0] i_cfg_data;

    nine_point_aim_calibration_mapper_unit uut (.*);

    // Local copy of the block's state.
    t_phase          cal_phase;
    int unsigned     slot;
    longint          yaw_store[9];
    longint          pitch_store[9];
    longint          ctr_x;
    longint          ctr_y;
    int              gain[4];
    longint unsigned scr_w;
    longint unsigned scr_h;

    t_out_res result_q[$];
    int       errors;
    int       sent;
    int       burst_left;
    int       idle_cycles;
    int       stall_mode;

    typedef struct {
        t_in_req  req;
        bit       typed;
        t_out_res res;
    } t_row;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_in_req mk(t_req rq, int yaw, int pitch, bit trig);
        t_in_req r;
        r.req_type    = rq;
        r.yaw_angle   = yaw[15:0];
        r.pitch_angle = pitch[15:0];
        r.trigger     = trig;
        return r;
    endfunction

    function automatic longint avg_of(longint a, longint b, longint c);
        return (a + b + c) / 3;
    endfunction

    // Pixels per degree in Q10.22: (half screen - margin) over the angle span.
    function automatic int side_gain(longint unsigned sz, longint span);
        longint num;
        longint q;
        num = (longint'(sz / 2) - EDGE_MARGIN) * ONE_Q22;
        if (span == 0) begin
            if (num > 0) return 32'sh7FFF_FFFF;
            if (num < 0) return 32'sh8000_0000;
            return 0;
        end
        q = num / span;
        if (q > 64'sh7FFF_FFFF) q = 64'sh7FFF_FFFF;
        if (q < -64'sh8000_0000) q = -64'sh8000_0000;
        return int'(q);
    endfunction

    function automatic logic [15:0] axis_pos(longint unsigned sz, longint diff, int g);
        longint unsigned md;
        longint unsigned mg;
        longint unsigned mp;
        longint          pix;
        longint          full;
        bit              neg;
        if (sz == 0) return 16'd0;
        neg  = (diff < 0) != (g < 0);
        md   = (diff < 0) ? longint'(-diff) : diff;
        mg   = (g < 0) ? -longint'(g) : longint'(g);
        mp   = (md != 0 && mg > PROD_CAP / md) ? PROD_CAP : md * mg;
        pix  = longint'(sz / 2) * ONE_Q22 + (neg ? -longint'(mp) : longint'(mp));
        full = longint'(sz) * ONE_Q22;
        if (pix < 0) pix = 0;
        if (pix > full) pix = full;
        return 16'((unsigned'(pix) * 65535) / unsigned'(full));
    endfunction

    // Advances the local state by one request and returns the result it gives.
    function automatic t_out_res map_request(t_in_req r);
        t_out_res o;
        longint   yaw;
        longint   pitch;
        longint   lft, rgt, upv, dnv;
        yaw   = longint'(signed'(r.yaw_angle));
        pitch = longint'(signed'(r.pitch_angle));
        o = '{ST_IGNORED, 16'd0, 16'd0, 1'b0};
        if (r.req_type == REQ_START) begin
            cal_phase = PH_CAL;
            slot      = 0;
            o.status  = ST_STORED;
        end else if (r.req_type == REQ_CAL && cal_phase == PH_CAL) begin
            if (slot > 8) begin
                slot = 0;
            end else begin
                yaw_store[slot]   = yaw;
                pitch_store[slot] = pitch;
                if (slot == 8) begin
                    lft   = avg_of(yaw_store[0], yaw_store[1], yaw_store[2]);
                    rgt   = avg_of(yaw_store[6], yaw_store[7], yaw_store[8]);
                    upv   = avg_of(pitch_store[0], pitch_store[5], pitch_store[6]);
                    dnv   = avg_of(pitch_store[2], pitch_store[3], pitch_store[8]);
                    ctr_x = avg_of(yaw_store[3], yaw_store[4], yaw_store[5]);
                    ctr_y = avg_of(pitch_store[1], pitch_store[4], pitch_store[7]);
                    gain[GN_LEFT]  = side_gain(scr_w, ctr_x - lft);
                    gain[GN_RIGHT] = side_gain(scr_w, rgt - ctr_x);
                    gain[GN_DOWN]  = side_gain(scr_h, ctr_y - dnv);
                    gain[GN_UP]    = side_gain(scr_h, upv - ctr_y);
                    slot      = 0;
                    cal_phase = PH_READY;
                    o.status  = ST_CAL_DONE;
                end else begin
                    slot++;
                    o.status = ST_STORED;
                end
            end
        end else if (r.req_type == REQ_AIM && cal_phase == PH_READY) begin
            o.x_position = axis_pos(scr_w, yaw - ctr_x,
                                    (yaw < ctr_x) ? gain[GN_LEFT] : gain[GN_RIGHT]);
            o.y_position = axis_pos(scr_h, ctr_y - pitch,
                                    (pitch < ctr_y) ? gain[GN_DOWN] : gain[GN_UP]);
            o.shot   = r.trigger;
            o.status = ST_POSITION;
        end
        return o;
    endfunction

    // Sends one request in bursts with random gaps; the expected result is
    // queued once the block takes it.
    task automatic send_req(t_in_req r, bit typed, t_out_res tres);
        t_out_res p;
        int       gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in       = r;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        p = map_request(r);
        result_q.push_back(typed ? tres : p);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid = 1'b0;
        while (result_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [SIZE_W-1:0] val);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_WIDTH) scr_w = 64'(val);
        else scr_h = 64'(val);
    endtask

    function automatic int jitter(int v);
        return v + $urandom_range(0, 16) - 8;
    endfunction

    // A calibration with random geometry, then a run of aims; stray requests of any type are mixed in.
    task automatic random_session();
        int cl, cc, cr, pt, pm, pb, span, n;
        int yc[9];
        int pr[9];
        t_out_res none;
        none = '{ST_IGNORED, 16'd0, 16'd0, 1'b0};
        cc   = $urandom_range(0, 4000) - 2000;
        pm   = $urandom_range(0, 4000) - 2000;
        span = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 3000);
        cl = cc - span; cr = cc + $urandom_range(0, 3000);
        pt = pm + span; pb = pm - $urandom_range(0, 3000);
        if ($urandom_range(0, 7) == 0) begin
            cl = $urandom_range(0, 65535) - 32768;
            pb = $urandom_range(0, 65535) - 32768;
        end
        yc = '{cl, cl, cl, cc, cc, cc, cr, cr, cr};
        pr = '{pt, pm, pb, pb, pm, pt, pt, pm, pb};
        send_req(mk(REQ_START, $urandom, $urandom, $urandom_range(0, 1)), 0, none);
        for (int i = 0; i < 9; i++) begin
            if ($urandom_range(0, 40) == 0)
                send_req(mk(t_req'($urandom_range(0, 3)), $urandom, $urandom,
                            $urandom_range(0, 1)), 0, none);
            send_req(mk(REQ_CAL, jitter(yc[i]), jitter(pr[i]), $urandom_range(0, 1)),
                     0, none);
        end
        n = $urandom_range(5, 60);
        for (int i = 0; i < n && sent < N_ITEMS; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_req(mk(t_req'($urandom_range(0, 3)), $urandom, $urandom,
                            $urandom_range(0, 1)), 0, none);
            else if ($urandom_range(0, 5) == 0)
                send_req(mk(REQ_AIM, $urandom, $urandom, $urandom_range(0, 1)), 0, none);
            else
                send_req(mk(REQ_AIM, $urandom_range(0, 8000) + cl - 1000,
                            $urandom_range(0, 8000) + pb - 1000, $urandom_range(0, 1)),
                         0, none);
        end
    endtask

    // Receiver stall pattern: it switches between free, light and heavy stalling.
    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            default: i_out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Result check against the oldest expectation.
    always @(posedge i_clk) begin
        t_out_res e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (result_q.size() == 0) begin
                $display("%0t: unexpected result %p", $time, o_out);
                errors++;
            end else begin
                e = result_q.pop_front();
                if (o_out.status !== e.status) begin
                    $display("%0t: status expected %0d got %0d", $time, e.status, o_out.status);
                    errors++;
                end
                if (o_out.x_position !== e.x_position) begin
                    $display("%0t: x_position expected %0d got %0d", $time,
                             e.x_position, o_out.x_position);
                    errors++;
                end
                if (o_out.y_position !== e.y_position) begin
                    $display("%0t: y_position expected %0d got %0d", $time,
                             e.y_position, o_out.y_position);
                    errors++;
                end
                if (o_out.shot !== e.shot) begin
                    $display("%0t: shot expected %0d got %0d", $time, e.shot, o_out.shot);
                    errors++;
                end
            end
        end
    end

    // Watchdog: too many cycles without any handshake on either side.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WD_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        t_row     rows[];
        t_out_res ign, st, dn;
        int       w_set[6];
        int       h_set[6];
        i_clk = 1'b0; i_rst_n = 1'b0; i_in_valid = 1'b0; i_in = '0;
        i_cfg_we = 1'b0; i_cfg_idx = CFG_WIDTH; i_cfg_data = '0;
        i_out_stall = 1'b0; stall_mode = 0; idle_cycles = 0;
        errors = 0; sent = 0; burst_left = 0;
        cal_phase = PH_IDLE; slot = 0; ctr_x = 0; ctr_y = 0;
        gain = '{0, 0, 0, 0}; scr_w = 64'(WIDTH_RST); scr_h = 64'(HEIGHT_RST);
        ign = '{ST_IGNORED, 16'd0, 16'd0, 1'b0};
        st  = '{ST_STORED, 16'd0, 16'd0, 1'b0};
        dn  = '{ST_CAL_DONE, 16'd0, 16'd0, 1'b0};

        // Directed part: ignored requests, one full calibration at extreme
        // angles, aims at the corners, and a calibration with zero spans.
        rows = '{
            '{mk(REQ_AIM, 100, 100, 1), 1, ign},
            '{mk(REQ_CAL, 5, 5, 0), 1, ign},
            '{mk(REQ_BAD, -1, -1, 1), 1, ign},
            '{mk(REQ_START, 0, 0, 0), 1, st},
            '{mk(REQ_CAL, -32768, 32767, 0), 1, st},
            '{mk(REQ_CAL, -640, 0, 1), 1, st},
            '{mk(REQ_CAL, -640, -320, 0), 1, st},
            '{mk(REQ_CAL, 0, -320, 0), 1, st},
            '{mk(REQ_CAL, 0, 0, 0), 1, st},
            '{mk(REQ_CAL, 0, 320, 0), 1, st},
            '{mk(REQ_CAL, 640, 320, 0), 1, st},
            '{mk(REQ_CAL, 640, 0, 0), 1, st},
            '{mk(REQ_CAL, 32767, -32768, 1), 1, dn},
            '{mk(REQ_AIM, 0, 0, 1), 0, ign},
            '{mk(REQ_AIM, 32767, -32768, 1), 0, ign},
            '{mk(REQ_AIM, -32768, 32767, 0), 0, ign},
            '{mk(REQ_AIM, -300, 150, 1), 0, ign},
            '{mk(REQ_START, 0, 0, 0), 1, st},
            '{mk(REQ_CAL, 77, -77, 0), 0, ign},
            '{mk(REQ_CAL, 77, -77, 0), 0, ign},
            '{mk(REQ_CAL, 77, -77, 0), 0, ign},
            '{mk(REQ_CAL, 77, -77, 0), 0, ign},
            '{mk(REQ_CAL, 77, -77, 0), 0, ign},
            '{mk(REQ_CAL, 77, -77, 0), 0, ign},
            '{mk(REQ_CAL, 77, -77, 0), 0, ign},
            '{mk(REQ_CAL, 77, -77, 0), 0, ign},
            '{mk(REQ_CAL, 77, -77, 0), 1, dn},
            '{mk(REQ_AIM, 78, -78, 1), 0, ign},
            '{mk(REQ_AIM, 76, -76, 0), 0, ign}
        };

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[i]) send_req(rows[i].req, rows[i].typed, rows[i].res);

        // Screen settings for the random phases, extremes among them; a zero
        // size pins that axis to zero.
        w_set = '{64, 4096, 8191, 0, 1920, 1280};
        h_set = '{4096, 64, 0, 8191, 1080, 720};
        w_set[5] = $urandom_range(64, 4096);
        h_set[5] = $urandom_range(64, 4096);
        for (int ph = 0; ph < 6; ph++) begin
            // Hold off until every result is back; the block is idle then.
            drain();
            write_cfg(CFG_WIDTH, SIZE_W'(w_set[ph]));
            write_cfg(CFG_HEIGHT, SIZE_W'(h_set[ph]));
            while (sent < N_ITEMS * (ph + 1) / 6) random_session();
        end

        i_in_valid = 1'b0;
        while (result_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
